/* hw/rtl/all_motifs_substring_check_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the motif substring checker
// Two clocked property forms, both disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ALL_MOTIFS_SUBSTRING_CHECK_TOP_ASSERT_SVH
`define ALL_MOTIFS_SUBSTRING_CHECK_TOP_ASSERT_SVH

// Same-cycle implication
`define AMSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define AMSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/amsc_pkg.sv */
// ----------------------------------------------------------------------------
// amsc_pkg
// Shared widths, register map codes, types and helpers for the motif
// substring checker.
// ----------------------------------------------------------------------------
package amsc_pkg;

    // Fixed field widths
    localparam int unsigned LETTER_W   = 8;
    localparam int unsigned TEXT_W     = 64;
    localparam int unsigned TEXT_BYTES = TEXT_W / LETTER_W;
    localparam int unsigned BYTE_IDX_W = $clog2(TEXT_BYTES);
    localparam int unsigned LEN_REG_W  = 4;

    // Register map
    localparam int unsigned SLOT_REGS     = 4;
    localparam int unsigned CFG_TEXT_BASE = 0;
    localparam int unsigned CFG_LEN_BASE  = SLOT_REGS;
    localparam int unsigned CFG_IDX_W     = 4;
    localparam int unsigned CFG_DATA_W    = TEXT_W;

    // Default configuration of the top level
    localparam int unsigned DEF_MOTIF_SLOTS   = 4;
    localparam int unsigned DEF_MOTIF_MAX_LEN = 8;

    typedef logic [LETTER_W-1:0]   letter_t;
    typedef logic [TEXT_W-1:0]     text_t;
    typedef logic [LEN_REG_W-1:0]  len_reg_t;
    typedef logic [BYTE_IDX_W-1:0] byte_idx_t;

    // Pick one character out of a packed motif, first character lowest
    function automatic letter_t text_byte(text_t t, byte_idx_t i);
        return t[LETTER_W * i +: LETTER_W];
    endfunction

endpackage

/* hw/rtl/all_motifs_substring_check_top.sv */
// ----------------------------------------------------------------------------
// all_motifs_substring_check_top
// Streams the letters of a sequence and reports, on its last letter, whether
// every configured motif occurred in it as a contiguous substring.
// ----------------------------------------------------------------------------
// One letter is taken every clock cycle, back to back, with no gaps between
// sequences, for as long as the result side is not stalled. Each letter is
// matched against all motifs in the cycle it arrives, through a row of
// MOTIF_MAX_LEN window cells that each compare one offset. The has_all beat
// for a sequence appears in the cycle after its last letter is accepted and
// is held in an output register. While that beat is stalled, in_stall
// follows out_stall and holds the letter stream. There is no start-up sweep
// after reset. Motif registers are to be written through the plain write
// port only while no sequence is in flight; the block itself does not
// enforce this. Length values above MOTIF_MAX_LEN act as MOTIF_MAX_LEN
// and an empty motif is always found.
// ----------------------------------------------------------------------------
module all_motifs_substring_check_top #(
    parameter int unsigned MOTIF_SLOTS   = amsc_pkg::DEF_MOTIF_SLOTS,
    parameter int unsigned MOTIF_MAX_LEN = amsc_pkg::DEF_MOTIF_MAX_LEN
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [amsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [amsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Letter stream
    input  logic                             in_valid,
    output logic                             in_stall,
    input  amsc_pkg::letter_t                letter,
    input  logic                             seq_end,
    // Result stream
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             has_all
);
    import amsc_pkg::*;

    localparam int unsigned LEN_W = $clog2(MOTIF_MAX_LEN + 1);

    text_t    [MOTIF_SLOTS-1:0]            text_reg;
    len_reg_t [MOTIF_SLOTS-1:0]            len_reg;
    logic     [MOTIF_SLOTS-1:0][LEN_W-1:0] len_eff;
    logic     [MOTIF_SLOTS-1:0]            empty;

    letter_t  [MOTIF_MAX_LEN-1:0]                  win;
    logic     [MOTIF_MAX_LEN-1:0][MOTIF_SLOTS-1:0] cell_hit;

    logic [LEN_W-1:0]       seen_reg;
    logic [LEN_W-1:0]       seen_next;
    logic [LEN_W-1:0]       seen_now;
    logic [MOTIF_SLOTS-1:0] found_reg;
    logic [MOTIF_SLOTS-1:0] found_next;
    logic [MOTIF_SLOTS-1:0] found_now;
    logic [MOTIF_SLOTS-1:0] match;
    logic                   all_found;

    logic out_valid_reg;
    logic out_valid_next;
    logic has_all_reg;
    logic has_all_next;
    logic in_take;

    // Motif registers; writes to unused slots or unknown indexes are dropped
    for (genvar s = 0; s < MOTIF_SLOTS; s++)
    begin : g_slot
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                text_reg[s] <= '0;
                len_reg[s]  <= '0;
            end
            else if (cfg_we)
            begin
                if (cfg_index == CFG_IDX_W'(CFG_TEXT_BASE + s))
                begin
                    text_reg[s] <= cfg_data;
                end
                if (cfg_index == CFG_IDX_W'(CFG_LEN_BASE + s))
                begin
                    len_reg[s] <= cfg_data[LEN_REG_W-1:0];
                end
            end
        end

        // Saturate the length at the longest motif
        assign len_eff[s] = (len_reg[s] > LEN_REG_W'(MOTIF_MAX_LEN))
                          ? LEN_W'(MOTIF_MAX_LEN) : LEN_W'(len_reg[s]);
        assign empty[s]   = (len_eff[s] == '0);
    end

    // Hand-shake: take a letter unless a finished result is held up
    assign in_stall = out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    // Row of window cells, newest letter at offset zero
    assign win[0] = letter;

    for (genvar k = 0; k < MOTIF_MAX_LEN; k++)
    begin : g_cell
        if (k < MOTIF_MAX_LEN - 1)
        begin : g_link
            amsc_cell #(
                .SLOTS   (MOTIF_SLOTS),
                .MAX_LEN (MOTIF_MAX_LEN),
                .K       (k)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .adv_i  (in_take),
                .data_i (win[k]),
                .text_i (text_reg),
                .len_i  (len_eff),
                .data_o (win[k+1]),
                .hit_o  (cell_hit[k])
            );
        end
        else
        begin : g_tail
            amsc_cell #(
                .SLOTS   (MOTIF_SLOTS),
                .MAX_LEN (MOTIF_MAX_LEN),
                .K       (k)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .adv_i  (in_take),
                .data_i (win[k]),
                .text_i (text_reg),
                .len_i  (len_eff),
                .data_o (),
                .hit_o  (cell_hit[k])
            );
        end
    end

    // Count letters including this one, saturating at the longest motif
    assign seen_now = (seen_reg == LEN_W'(MOTIF_MAX_LEN)) ? seen_reg
                                                          : seen_reg + LEN_W'(1);

    // Combine the cell votes per motif
    always_comb
    begin
        for (int s = 0; s < MOTIF_SLOTS; s++)
        begin
            match[s] = !empty[s] && (seen_now >= len_eff[s]);
            for (int k = 0; k < MOTIF_MAX_LEN; k++)
            begin
                match[s] = match[s] && cell_hit[k][s];
            end
        end
    end

    assign found_now = found_reg | match;
    assign all_found = &(found_now | empty);

    // Sequence state: clear after the last letter
    always_comb
    begin
        seen_next  = seen_reg;
        found_next = found_reg;
        if (in_take)
        begin
            if (seq_end)
            begin
                seen_next  = '0;
                found_next = '0;
            end
            else
            begin
                seen_next  = seen_now;
                found_next = found_now;
            end
        end
    end

    // Output register: load on the last letter, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        has_all_next   = has_all_reg;
        if (in_take && seq_end)
        begin
            out_valid_next = 1'b1;
            has_all_next   = all_found;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= '0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
            has_all_reg   <= 1'b0;
        end
        else
        begin
            seen_reg      <= seen_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            has_all_reg   <= has_all_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign has_all   = has_all_reg;

endmodule

/* hw/rtl/amsc_cell.sv */
// ----------------------------------------------------------------------------
// amsc_cell
// One position of the letter window: compares the letter at its offset with
// the matching character of every motif and hands the letter on to the next
// cell when a beat is accepted.
// ----------------------------------------------------------------------------
module amsc_cell #(
    parameter int unsigned SLOTS   = 4,
    parameter int unsigned MAX_LEN = 8,
    parameter int unsigned K       = 0
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     adv_i,
    input  amsc_pkg::letter_t                        data_i,
    input  amsc_pkg::text_t [SLOTS-1:0]              text_i,
    input  logic [SLOTS-1:0][$clog2(MAX_LEN+1)-1:0]  len_i,
    output amsc_pkg::letter_t                        data_o,
    output logic [SLOTS-1:0]                         hit_o
);
    import amsc_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);

    letter_t data_reg;
    letter_t data_next;

    // Compare: offsets at or beyond the motif length do not constrain it
    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            hit_o[s] = 1'b1;
            if (LEN_W'(K) < len_i[s])
            begin
                hit_o[s] = (data_i == text_byte(text_i[s],
                    BYTE_IDX_W'(len_i[s] - LEN_W'(K) - LEN_W'(1))));
            end
        end
    end

    // Advance the window on every accepted beat
    assign data_next = adv_i ? data_i : data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data_o = data_reg;

endmodule

/* hw/rtl/amsc_checker.sv */
// ----------------------------------------------------------------------------
// amsc_checker
// Port-level checks for the motif substring checker, bound to the top level.
// ----------------------------------------------------------------------------
`include "all_motifs_substring_check_top_assert.svh"

module amsc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic seq_end,
    input logic out_valid,
    input logic out_stall,
    input logic has_all
);
    logic in_take;
    logic end_take;
    logic out_held;

    assign in_take  = in_valid && !in_stall;
    assign end_take = in_take && seq_end;
    assign out_held = out_valid && out_stall;

    // Hold a stalled result beat
    `AMSC_ASSERT_NEXT(a_out_hold, out_held, out_valid, "result beat dropped while stalled")
    `AMSC_ASSERT_NEXT(a_out_stable, out_held, $stable(has_all), "stalled has_all changed")

    // Stall the letter stream only while a result is held up
    `AMSC_ASSERT_NOW(a_in_stall, 1'b1, in_stall == out_held, "letter stall without a held result")

    // A last letter gives a result beat in the next cycle
    `AMSC_ASSERT_NEXT(a_end_result, end_take, out_valid, "no result after last letter")

    // A fresh result beat follows an accepted last letter
    `AMSC_ASSERT_NOW(a_no_spurious, out_valid && !$past(out_held), $past(end_take), "stray result")

endmodule

bind all_motifs_substring_check_top amsc_checker u_amsc_checker (.*);

/* sim/all_motifs_substring_check_top_test.sv */
// ----------------------------------------------------------------------------
// all_motifs_substring_check_top_test
// Streams letter sequences through the motif substring checker and compares
// every has_all beat with an in-bench prediction. The run starts with
// directed sequences: empty motifs, motifs longer than the sequence,
// saturated lengths and matches ending on the last letter. Random sequences
// follow that mostly plant the configured motifs among filler letters. Both
// handshakes idle at random save in the last phases; motifs change per phase.
// ----------------------------------------------------------------------------
module all_motifs_substring_check_top_test;
    import amsc_pkg::*;

    localparam int unsigned SLOTS          = DEF_MOTIF_SLOTS;
    localparam int unsigned MAX_LEN        = DEF_MOTIF_MAX_LEN;
    localparam int unsigned HIST           = MAX_LEN - 1;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned QUIET_LIMIT    = 5000;
    localparam int unsigned MAX_SHOWN      = 10;
    localparam int unsigned RAND_PER_PHASE = 115;

    // Register indexes past the end of the map, which the block ignores
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = CFG_IDX_W'(2 * SLOT_REGS);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = '1;

    typedef struct packed {
        letter_t ch;
        logic    last;
    } letter_beat_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    letter_t               letter    = '0;
    logic                  seq_end   = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  has_all;

    // Stimulus side
    letter_beat_t pending_beats [$];
    letter_beat_t next_beat;
    int unsigned  queued_beats   = 0;
    int unsigned  send_gap_pct   = 0;
    int unsigned  recv_stall_pct = 0;
    logic         in_fire        = 1'b0;
    text_t        stim_text [SLOT_REGS];
    len_reg_t     stim_len  [SLOT_REGS];

    // Prediction side
    letter_t      prior_letters [HIST];
    logic [3:0]   run_len;
    logic [SLOT_REGS-1:0] hit_flags;
    text_t        pm_text [SLOT_REGS];
    len_reg_t     pm_len  [SLOT_REGS];
    logic         has_all_expected [$];
    logic         want;
    int unsigned  error_count = 0;
    int unsigned  quiet_cycles = 0;

    all_motifs_substring_check_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .letter    (letter),
        .seq_end   (seq_end),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .has_all   (has_all)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Length register as the matcher sees it
    function automatic int unsigned eff_len(len_reg_t raw);
        return (raw > MAX_LEN) ? MAX_LEN : raw;
    endfunction

    // Mostly nucleotide letters so that motifs turn up, now and then any byte
    function automatic letter_t random_letter();
        if ($urandom_range(9) == 0)
            return letter_t'($urandom_range(255));
        case ($urandom_range(3))
            0:       return "A";
            1:       return "C";
            2:       return "G";
            default: return "T";
        endcase
    endfunction

    // Advance the window by one letter and close the sequence on its last one
    task automatic scan_letter(input letter_t ch, input logic last);
        letter_t     win [MAX_LEN];
        int unsigned span;
        logic        match;
        logic        every;
        begin
            win[0] = ch;
            for (int k = 1; k < MAX_LEN; k++)
                win[k] = prior_letters[k-1];
            if (run_len < MAX_LEN)
                run_len = run_len + 1'b1;
            for (int s = 0; s < SLOTS; s++)
            begin
                span = eff_len(pm_len[s]);
                if (span != 0 && run_len >= span)
                begin
                    match = 1'b1;
                    for (int k = 0; k < span; k++)
                        if (win[span-1-k] != pm_text[s][LETTER_W*k +: LETTER_W])
                            match = 1'b0;
                    if (match)
                        hit_flags[s] = 1'b1;
                end
            end
            for (int k = 0; k < HIST; k++)
                prior_letters[k] = win[k];
            if (last)
            begin
                every = 1'b1;
                for (int s = 0; s < SLOTS; s++)
                    if (eff_len(pm_len[s]) != 0 && !hit_flags[s])
                        every = 1'b0;
                has_all_expected.insert(has_all_expected.size(), every);
                for (int k = 0; k < HIST; k++)
                    prior_letters[k] = '0;
                run_len   = '0;
                hit_flags = '0;
            end
        end
    endtask

    task automatic push_beat(input letter_t ch, input logic last);
        pending_beats.insert(pending_beats.size(), letter_beat_t'{ch: ch, last: last});
        queued_beats++;
    endtask

    // Plant a random choice of the motifs among filler letters
    task automatic queue_sequence();
        letter_t     body [$];
        int unsigned span;
        begin
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(3, 1)) body.insert(body.size(), random_letter());
            end
            else
            begin
                repeat ($urandom_range(3)) body.insert(body.size(), random_letter());
                for (int s = 0; s < SLOT_REGS; s++)
                begin
                    if ($urandom_range(99) < 75)
                    begin
                        span = eff_len(stim_len[s]);
                        for (int k = 0; k < span; k++)
                            body.insert(body.size(), stim_text[s][LETTER_W*k +: LETTER_W]);
                        repeat ($urandom_range(3)) body.insert(body.size(), random_letter());
                    end
                end
                if (body.size() == 0)
                    body.insert(body.size(), random_letter());
            end
            foreach (body[i])
                push_beat(body[i], i == body.size() - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input text_t value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Length written with random upper bits, which the register drops
    task automatic set_motif(input int unsigned slot, input text_t text, input len_reg_t len);
        text_t len_word;
        begin
            len_word = {$urandom, $urandom};
            len_word[LEN_REG_W-1:0] = len;
            write_reg(CFG_IDX_W'(CFG_TEXT_BASE + slot), text);
            write_reg(CFG_IDX_W'(CFG_LEN_BASE + slot), len_word);
            stim_text[slot] = text;
            stim_len[slot]  = len;
        end
    endtask

    task automatic randomise_motifs(input int unsigned lo, input int unsigned hi);
        text_t text;
        begin
            for (int s = 0; s < SLOT_REGS; s++)
            begin
                for (int k = 0; k < TEXT_BYTES; k++)
                    text[LETTER_W*k +: LETTER_W] = random_letter();
                set_motif(s, text, len_reg_t'($urandom_range(hi, lo)));
            end
        end
    endtask

    // Hold until every beat is sent and every result has come back
    task automatic wait_idle();
        while (pending_beats.size() != 0 || in_valid || has_all_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Driver: present letter beats and the result stall on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_fire)
            begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    next_beat = pending_beats.pop_front();
                    letter   <= next_beat.ch;
                    seq_end  <= next_beat.last;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predict from accepted letters, check results, track the registers
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire      <= 1'b0;
            run_len      = '0;
            hit_flags    = '0;
            quiet_cycles = 0;
            for (int k = 0; k < HIST; k++)
                prior_letters[k] = '0;
            for (int s = 0; s < SLOT_REGS; s++)
            begin
                pm_text[s] = '0;
                pm_len[s]  = '0;
            end
        end
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                scan_letter(letter, seq_end);

            if (out_valid && !out_stall)
            begin
                if (has_all_expected.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                        $display("unexpected has_all beat: got %0b", has_all);
                end
                else
                begin
                    want = has_all_expected.pop_front();
                    if (has_all !== want)
                    begin
                        error_count++;
                        if (error_count <= MAX_SHOWN)
                            $display("has_all mismatch: expected %0b got %0b", want, has_all);
                    end
                end
            end

            if (cfg_we)
            begin
                if (cfg_index >= CFG_TEXT_BASE && cfg_index < CFG_TEXT_BASE + SLOT_REGS)
                    pm_text[cfg_index - CFG_TEXT_BASE] = cfg_data;
                else if (cfg_index >= CFG_LEN_BASE && cfg_index < CFG_LEN_BASE + SLOT_REGS)
                    pm_len[cfg_index - CFG_LEN_BASE] = cfg_data[LEN_REG_W-1:0];
            end

            // Watchdog: give up when nothing moves for too long
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("FAIL all_motifs_substring_check_top");
                $finish;
            end
        end
    end

    // Stimulus: directed sequences first, then random phases
    initial
    begin
        int unsigned start_count;

        for (int s = 0; s < SLOT_REGS; s++)
        begin
            stim_text[s] = '0;
            stim_len[s]  = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Sender idles little, receiver stalls a lot
        send_gap_pct   = 21;
        recv_stall_pct = 84;

        // Reset motifs are all empty, so every sequence passes
        push_beat(8'hFF, 1'b1);
        push_beat(8'h00, 1'b0);
        push_beat(8'h80, 1'b1);
        wait_idle();

        // Short pair, empty slot, saturated eight-letter run, single zero byte
        set_motif(0, 64'h4241, 4'd2);
        set_motif(1, '1, 4'd0);
        set_motif(2, '1, 4'd15);
        set_motif(3, '0, 4'd1);
        write_reg(CFG_IDX_SPARE_LO, '1);
        write_reg(CFG_IDX_SPARE_HI, '0);

        // Single letter: the longer motifs cannot fit
        push_beat(8'h00, 1'b1);
        // All present, the eight-letter run ending on the last letter
        push_beat("A", 1'b0);
        push_beat("B", 1'b0);
        push_beat(8'h00, 1'b0);
        repeat (7) push_beat(8'hFF, 1'b0);
        push_beat(8'hFF, 1'b1);
        // Run one letter short
        push_beat(8'h00, 1'b0);
        push_beat("A", 1'b0);
        push_beat("B", 1'b0);
        repeat (6) push_beat(8'hFF, 1'b0);
        push_beat(8'hFF, 1'b1);
        wait_idle();

        for (int r = 0; r < 6; r++)
        begin
            if (r == 2)
            begin
                send_gap_pct   = 84;
                recv_stall_pct = 21;
            end
            else if (r == 4)
            begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            case (r)
                0:       randomise_motifs(8, 8);
                1:       randomise_motifs(0, 15);
                2:       randomise_motifs(0, 3);
                3:       randomise_motifs(9, 15);
                4:       randomise_motifs(0, 8);
                default: randomise_motifs(1, 2);
            endcase
            start_count = queued_beats;
            while (queued_beats - start_count < RAND_PER_PHASE)
                queue_sequence();
            wait_idle();
        end

        if (error_count == 0 && has_all_expected.size() == 0)
            $display("PASS all_motifs_substring_check_top");
        else
            $display("FAIL all_motifs_substring_check_top");
        $finish;
    end

endmodule
